// ===== rtl/core/rwbc_pkg.sv =====
// Shared constants, types and fixed-point helpers for the balance controller.
package rwbc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DT_BITS   = 16;
    localparam int AXES      = 3;
    localparam int CORDIC_STEPS = 28;

    localparam logic [4:0] SH_FRAC  = 5'(FRAC_BITS);
    localparam logic [4:0] SH_DT    = 5'(DT_BITS);
    localparam logic [4:0] SH_Q30   = 5'(30 - FRAC_BITS);
    localparam int         WHL_SH   = FRAC_BITS - 8;

    localparam logic signed [65:0] PI_HALF_Q30    = 66'sd1686629713;
    localparam logic signed [65:0] PI_QUARTER_Q30 = 66'sd843314857;
    localparam logic signed [32:0] GYRO_SCALE_Q30 = 33'sd142977;
    localparam logic [16:0]        WEIGHT_ONE     = 17'd65536;
    localparam logic [15:0]        WHEEL_SLOW     = 16'd25600;

    localparam logic signed [31:0] TILT_OFF [AXES] = '{
        32'sd42949673, -32'sd53687091, -32'sd21474836
    };

    // configuration register indexes
    localparam logic [2:0] CFG_GAIN_ANGLE = 3'd0;
    localparam logic [2:0] CFG_GAIN_RATE  = 3'd1;
    localparam logic [2:0] CFG_GAIN_WHEEL = 3'd2;
    localparam logic [2:0] CFG_PRIOR_W    = 3'd3;
    localparam logic [2:0] CFG_SP_RATE    = 3'd4;
    localparam logic [2:0] CFG_SP_LIMIT   = 3'd5;

    // round half up, then arithmetic shift; s is never zero here
    function automatic logic signed [65:0] rnd(input logic signed [65:0] v,
                                               input logic [4:0] s);
        logic signed [65:0] half;
        half = 66'sd1 <<< (s - 5'd1);
        return (v + half) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic [16:0] mag16(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = 17'(v);
        return e[16] ? 17'(-e) : 17'(e);
    endfunction

    // arctangent of 2^-i in Q30
    function automatic logic [30:0] atan_step(input logic [4:0] i);
        case (i)
            5'd0:    return 31'd843314857;
            5'd1:    return 31'd497837829;
            5'd2:    return 31'd263043837;
            5'd3:    return 31'd133525159;
            5'd4:    return 31'd67021687;
            5'd5:    return 31'd33543516;
            5'd6:    return 31'd16775851;
            5'd7:    return 31'd8388437;
            5'd8:    return 31'd4194283;
            5'd9:    return 31'd2097149;
            5'd10:   return 31'd1048576;
            default: return 31'd1 << (5'd30 - i);
        endcase
    endfunction

endpackage

// ===== rtl/core/reaction_wheel_balance_controller_core.sv =====
// Top level: sequencer, state and output register of the balance controller.
// Per item: the three axes in turn, each paced by the 28-step arctangent CORDIC,
//   which the eleven multiplies of an axis partly overlap; a zero numerator or
//   denominator skips the CORDIC.
// Throughput: one item at a time; the input is ready again as soon as the
//   result is in the output register, even while that result waits.
// Reset: synchronous, active low; clears estimate, torques, setpoint shifts,
//   and loads the register defaults (weight 3277, drain 655360, limit 6554).
module reaction_wheel_balance_controller_core
    import rwbc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,
    input  logic [15:0]        i_wheel_speed_a,
    input  logic [15:0]        i_wheel_speed_b,
    input  logic [15:0]        i_wheel_speed_c,
    input  logic [15:0]        i_time_step,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_torque_a,
    output logic signed [31:0] o_torque_b,
    output logic signed [31:0] o_torque_c,
    output logic signed [16:0] o_signed_wheel_a,
    output logic signed [16:0] o_signed_wheel_b,
    output logic signed [16:0] o_signed_wheel_c
);

    // Per axis: predict, gyro scale, wheel prediction, drain (two halves),
    // wait for tilt, blend, then the PD torque as three rounded products.
    typedef enum logic [4:0] {
        S_IDLE, S_M1, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_WAIT,
        S_A1, S_A2, S_A3, S_T1, S_T2, S_T3, S_T4, S_T5, S_FIN
    } t_state;

    t_state r_state;
    logic [1:0] r_ax;

    // configuration registers
    logic signed [31:0] r_gain_angle, r_gain_rate, r_gain_wheel;
    logic [16:0]        r_prior_w;
    logic [30:0]        r_sp_rate, r_sp_limit;

    // captured item
    logic signed [15:0] r_acc_x, r_acc_y, r_acc_z;
    logic signed [15:0] r_gyr_x, r_gyr_y, r_gyr_z;
    logic [15:0]        r_spd [AXES];
    logic [15:0]        r_dt;

    // filter state, each array read only at the current axis
    logic signed [31:0] r_ang [AXES];
    logic signed [31:0] r_rate [AXES];
    logic signed [31:0] r_whl [AXES];
    logic signed [31:0] r_lt [AXES];
    logic signed [31:0] r_ss [AXES];

    // working registers
    logic signed [31:0] r_pri, r_meas;
    logic signed [65:0] r_acc;
    logic signed [47:0] r_drain;
    logic signed [31:0] r_tq [AXES];
    logic signed [16:0] r_sw [AXES];

    // output register
    logic               r_ovalid;
    logic signed [31:0] r_o_tq [AXES];
    logic signed [16:0] r_o_sw [AXES];

    // shared units
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic               atan_start, atan_done;
    logic [30:0]        atan_z;
    logic [16:0]        num_sel, den_sel;

    logic [16:0]        w_cl;
    logic [27:0]        dt4000;
    logic signed [16:0] gyro_sel;
    logic [15:0]        spd_sel;
    logic signed [65:0] wp, dd, s_new, lim, err66, ang66, meas66;
    logic               wneg;
    logic signed [16:0] sw_n;

    rwbc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    rwbc_atan u_atan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (atan_start),
        .i_num   (num_sel),
        .i_den   (den_sel),
        .o_done  (atan_done),
        .o_angle (atan_z)
    );

    // per-axis selection; z axes are negated, magnitudes make that moot for tilt
    always_comb begin
        case (r_ax)
            2'd0: begin
                num_sel  = mag16(r_acc_z);
                den_sel  = mag16(r_acc_y);
                gyro_sel = 17'(r_gyr_x);
            end
            2'd1: begin
                num_sel  = mag16(r_acc_x);
                den_sel  = mag16(r_acc_z);
                gyro_sel = 17'(r_gyr_y);
            end
            default: begin
                num_sel  = mag16(r_acc_y);
                den_sel  = mag16(r_acc_x);
                gyro_sel = -17'(r_gyr_z);
            end
        endcase
    end

    assign spd_sel    = r_spd[r_ax];
    assign w_cl       = (r_prior_w > WEIGHT_ONE) ? WEIGHT_ONE : r_prior_w;
    // 4000 = 4096 - 64 - 32
    assign dt4000     = (28'(r_dt) << 12) - (28'(r_dt) << 6) - (28'(r_dt) << 5);
    assign atan_start = (r_state == S_M1);

    assign wp     = 66'(r_whl[r_ax]) + rnd(mul_p, SH_DT);
    assign wneg   = wp[65];
    assign sw_n   = (wneg && spd_sel < WHEEL_SLOW) ? -$signed({1'b0, spd_sel})
                                                   : $signed({1'b0, spd_sel});
    assign dd     = r_acc + mul_p;
    assign s_new  = 66'(r_ss[r_ax]) - rnd(dd, SH_DT);
    assign lim    = $signed(66'(r_sp_limit));
    assign err66  = 66'(r_ang[r_ax]) - 66'(r_ss[r_ax]);
    assign ang66  = rnd(r_acc + mul_p, SH_DT);
    assign meas66 = rnd($signed(66'(atan_z)) - PI_QUARTER_Q30 + 66'(TILT_OFF[r_ax]),
                        SH_Q30);

    // multiplier operand selection by step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_M1: begin
                mul_a = 33'(r_rate[r_ax]);
                mul_b = $signed(33'(r_dt));
            end
            S_P1: begin
                mul_a = 33'(gyro_sel);
                mul_b = GYRO_SCALE_Q30;
            end
            S_P2: begin
                mul_a = 33'(r_lt[r_ax]);
                mul_b = $signed(33'(dt4000));
            end
            S_P3: begin
                mul_a = 33'(r_lt[r_ax]);
                mul_b = $signed(33'(r_sp_rate));
            end
            S_P5: begin
                // upper half carries the sign
                mul_a = 33'($signed(r_drain[47:24]));
                mul_b = $signed(33'(r_dt));
            end
            S_P6: begin
                mul_a = $signed(33'(r_drain[23:0]));
                mul_b = $signed(33'(r_dt));
            end
            S_A1: begin
                mul_a = 33'(r_meas);
                mul_b = $signed(33'(17'(WEIGHT_ONE - w_cl)));
            end
            S_A2: begin
                mul_a = 33'(r_pri);
                mul_b = $signed(33'(w_cl));
            end
            S_T1: begin
                mul_a = 33'(sat32(err66));
                mul_b = 33'(r_gain_angle);
            end
            S_T2: begin
                mul_a = 33'(r_rate[r_ax]);
                mul_b = 33'(r_gain_rate);
            end
            S_T3: begin
                mul_a = 33'(r_whl[r_ax]);
                mul_b = 33'(r_gain_wheel);
            end
            default: ;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_angle <= '0;
            r_gain_rate  <= '0;
            r_gain_wheel <= '0;
            r_prior_w    <= 17'd3277;
            r_sp_rate    <= 31'd655360;
            r_sp_limit   <= 31'd6554;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_GAIN_ANGLE: r_gain_angle <= i_cfg_data;
                CFG_GAIN_RATE:  r_gain_rate  <= i_cfg_data;
                CFG_GAIN_WHEEL: r_gain_wheel <= i_cfg_data;
                CFG_PRIOR_W:    r_prior_w    <= i_cfg_data[16:0];
                CFG_SP_RATE:    r_sp_rate    <= i_cfg_data[30:0];
                CFG_SP_LIMIT:   r_sp_limit   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // sequencer, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ax     <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < AXES; k++) begin
                r_ang[k]  <= '0;
                r_rate[k] <= '0;
                r_whl[k]  <= '0;
                r_lt[k]   <= '0;
                r_ss[k]   <= '0;
            end
        end else begin
            // the final step loads the output register itself
            if (r_ovalid && i_out_ready && r_state != S_FIN)
                r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_acc_x  <= i_accel_x;
                        r_acc_y  <= i_accel_y;
                        r_acc_z  <= i_accel_z;
                        r_gyr_x  <= i_gyro_x;
                        r_gyr_y  <= i_gyro_y;
                        r_gyr_z  <= i_gyro_z;
                        r_spd[0] <= i_wheel_speed_a;
                        r_spd[1] <= i_wheel_speed_b;
                        r_spd[2] <= i_wheel_speed_c;
                        r_dt     <= i_time_step;
                        r_ax     <= '0;
                        r_state  <= S_M1;
                    end
                end
                S_M1: r_state <= S_P1;
                S_P1: begin
                    r_pri   <= sat32(66'(r_ang[r_ax]) + rnd(mul_p, SH_DT));
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_rate[r_ax] <= sat32(rnd(mul_p, SH_Q30));
                    r_state      <= S_P3;
                end
                S_P3: begin
                    // slow wheels take the sign of the predicted velocity
                    r_sw[r_ax]  <= sw_n;
                    r_whl[r_ax] <= 32'(sw_n) <<< WHL_SH;
                    r_state     <= S_P4;
                end
                S_P4: begin
                    r_drain <= 48'(rnd(mul_p, SH_FRAC));
                    r_state <= S_P5;
                end
                S_P5: r_state <= S_P6;
                S_P6: begin
                    r_acc   <= mul_p <<< 24;
                    r_state <= S_P7;
                end
                S_P7: begin
                    if (s_new > lim)
                        r_ss[r_ax] <= lim[31:0];
                    else if (s_new < -lim)
                        r_ss[r_ax] <= 32'(-lim);
                    else
                        r_ss[r_ax] <= s_new[31:0];
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (atan_done) begin
                        r_meas  <= meas66[31:0];
                        r_state <= S_A1;
                    end
                end
                S_A1: r_state <= S_A2;
                S_A2: begin
                    r_acc   <= mul_p;
                    r_state <= S_A3;
                end
                S_A3: begin
                    r_ang[r_ax] <= sat32(ang66);
                    r_state     <= S_T1;
                end
                S_T1: r_state <= S_T2;
                S_T2: begin
                    r_acc   <= rnd(mul_p, SH_FRAC);
                    r_state <= S_T3;
                end
                S_T3: begin
                    r_acc   <= r_acc + rnd(mul_p, SH_FRAC);
                    r_state <= S_T4;
                end
                S_T4: begin
                    r_acc   <= r_acc - rnd(mul_p, SH_FRAC);
                    r_state <= S_T5;
                end
                S_T5: begin
                    r_lt[r_ax] <= sat32(r_acc);
                    r_tq[r_ax] <= sat32(r_acc);
                    if (r_ax == 2'(AXES - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_M1;
                    end
                end
                S_FIN: begin
                    // hold the item until the output register is free
                    if (!r_ovalid || i_out_ready) begin
                        for (int k = 0; k < AXES; k++) begin
                            r_o_tq[k] <= r_tq[k];
                            r_o_sw[k] <= r_sw[k];
                        end
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_ovalid;
    assign o_torque_a       = r_o_tq[0];
    assign o_torque_b       = r_o_tq[1];
    assign o_torque_c       = r_o_tq[2];
    assign o_signed_wheel_a = r_o_sw[0];
    assign o_signed_wheel_b = r_o_sw[1];
    assign o_signed_wheel_c = r_o_sw[2];

endmodule

// ===== rtl/core/rwbc_mul.sv =====
// Shared signed multiplier with registered product.
module rwbc_mul
    import rwbc_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);

    logic signed [65:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 66'(i_a) * 66'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== rtl/core/rwbc_atan.sv =====
// Iterative vectoring CORDIC: atan(n/d) in Q30 for non-negative n, d.
module rwbc_atan
    import rwbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [16:0] i_num,
    input  logic [16:0] i_den,
    output logic        o_done,
    output logic [30:0] o_angle
);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state             r_state;
    logic               r_done;
    logic [4:0]         r_i;
    logic signed [33:0] r_x, r_y;
    logic signed [32:0] r_z;

    logic signed [33:0] dx, dy, n_x, n_y;
    logic signed [32:0] a, n_z, z_cl;

    always_comb begin
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        a  = 33'(atan_step(r_i));
        if (!r_y[33]) begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + a;
        end else begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - a;
        end
        if (n_z < 0)
            z_cl = '0;
        else if (66'(n_z) > PI_HALF_Q30)
            z_cl = PI_HALF_Q30[32:0];
        else
            z_cl = n_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_i     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_i <= '0;
                        r_x <= 34'(i_den) <<< 14;
                        r_y <= 34'(i_num) <<< 14;
                        if (i_num == '0) begin
                            r_z    <= '0;
                            r_done <= 1'b1;
                        end else if (i_den == '0) begin
                            r_z    <= PI_HALF_Q30[32:0];
                            r_done <= 1'b1;
                        end else begin
                            r_z     <= '0;
                            r_done  <= 1'b0;
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    r_x <= n_x;
                    r_y <= n_y;
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'(CORDIC_STEPS - 1)) begin
                        r_z     <= z_cl;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_z <= n_z;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_z[30:0];

endmodule

// ===== rtl/core/rwbc_checker.sv =====
// Port-level checker for the balance controller, bound to the top level.
module rwbc_checker
    import rwbc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_torque_a,
    input logic signed [16:0] o_signed_wheel_a
);

    // an accepted item keeps the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready straight after an accepted item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_torque_a))
        else $error("stalled result dropped or changed");

    // signed wheel speed never reaches the most negative code
    a_wheel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_signed_wheel_a != -17'sd65536)
        else $error("signed wheel out of range");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind reaction_wheel_balance_controller_core rwbc_checker u_rwbc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_torque_a       (o_torque_a),
    .o_signed_wheel_a (o_signed_wheel_a)
);

// ===== sim/testbench.sv =====
// Testbench for the reaction wheel balance controller core.
`timescale 1ns / 1ps

module testbench;
    import rwbc_pkg::*;

    typedef struct packed {
        logic signed [31:0] torque_a;
        logic signed [31:0] torque_b;
        logic signed [31:0] torque_c;
        logic signed [16:0] wheel_a;
        logic signed [16:0] wheel_b;
        logic signed [16:0] wheel_c;
    } command_t;

    typedef struct packed {
        logic signed [15:0] ax, ay, az, gx, gy, gz;
        logic [15:0]        wa, wb, wc, dt;
    } sample_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    sample_t            smp = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] tq_a, tq_b, tq_c;
    logic signed [16:0] sw_a, sw_b, sw_c;

    // predictor state
    longint est [9];
    longint torque_hist [3];
    longint sp_shift [3];
    longint k_angle, k_rate, k_wheel, w_prior, sp_rate, sp_limit;

    command_t expected_cmds [$];
    int       mismatches = 0;
    bit       quiet_phase = 1'b0;  // no idling on either side when set

    reaction_wheel_balance_controller_core u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_accel_x(smp.ax), .i_accel_y(smp.ay), .i_accel_z(smp.az),
        .i_gyro_x(smp.gx), .i_gyro_y(smp.gy), .i_gyro_z(smp.gz),
        .i_wheel_speed_a(smp.wa), .i_wheel_speed_b(smp.wb),
        .i_wheel_speed_c(smp.wc), .i_time_step(smp.dt),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_torque_a(tq_a), .o_torque_b(tq_b), .o_torque_c(tq_c),
        .o_signed_wheel_a(sw_a), .o_signed_wheel_b(sw_b), .o_signed_wheel_c(sw_c)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // floor shift, valid for negatives too
    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_q(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint absval(longint v);
        return v < 0 ? -v : v;
    endfunction

    // CORDIC arctangent of n/d in Q30, n and d non-negative
    function automatic longint tilt_q30(longint n, longint d);
        longint x, y, z, dx, dy, a;
        longint tab [11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                             33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
        if (n == 0) return 0;
        if (d == 0) return 1686629713;
        x = d * 16384;
        y = n * 16384;
        z = 0;
        for (int i = 0; i < 28; i++) begin
            a = (i < 11) ? tab[i] : (longint'(1) <<< (30 - i));
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += a;
            end else begin
                x -= dx; y += dy; z -= a;
            end
        end
        if (z < 0) z = 0;
        if (z > 1686629713) z = 1686629713;
        return z;
    endfunction

    function automatic command_t balance_step(sample_t s);
        longint num [3], den [3], rate_raw [3], spd [3], nxt [9], sgn [3];
        longint offs [3] = '{42949673, -53687091, -21474836};
        longint dt, w, pri, meas, wp, drain, sh, err, u;
        command_t c;
        dt = longint'(s.dt);
        w = (w_prior > 65536) ? 65536 : w_prior;
        rate_raw[0] = longint'(s.gx);
        rate_raw[1] = longint'(s.gy);
        rate_raw[2] = -longint'(s.gz);
        num[0] = absval(longint'(s.az)); den[0] = absval(longint'(s.ay));
        num[1] = absval(longint'(s.ax)); den[1] = absval(longint'(s.az));
        num[2] = absval(longint'(s.ay)); den[2] = absval(longint'(s.ax));
        spd[0] = longint'(s.wa); spd[1] = longint'(s.wb); spd[2] = longint'(s.wc);
        for (int i = 0; i < 3; i++) begin
            pri = clip32(est[i] + round_q(est[3+i] * dt, 16));
            meas = round_q(tilt_q30(num[i], den[i]) - 843314857 + offs[i], 14);
            nxt[i] = clip32(round_q(meas * (65536 - w) + pri * w, 16));
            wp = est[6+i] + round_q(torque_hist[i] * 4000 * dt, 16);
            drain = round_q(torque_hist[i] * sp_rate, 16);
            drain = round_q(drain * dt, 16);
            sh = sp_shift[i] - drain;
            if (sh > sp_limit) sh = sp_limit;
            if (sh < -sp_limit) sh = -sp_limit;
            sp_shift[i] = sh;
            nxt[3+i] = clip32(round_q(rate_raw[i] * 142977, 14));
            sgn[i] = (wp < 0 && spd[i] < 25600) ? -spd[i] : spd[i];
            nxt[6+i] = clip32(sgn[i] * 256);
        end
        for (int i = 0; i < 9; i++) est[i] = nxt[i];
        for (int i = 0; i < 3; i++) begin
            err = clip32(est[i] - sp_shift[i]);
            u = round_q(err * k_angle, 16) + round_q(est[3+i] * k_rate, 16)
                - round_q(est[6+i] * k_wheel, 16);
            torque_hist[i] = clip32(u);
        end
        c.torque_a = torque_hist[0][31:0];
        c.torque_b = torque_hist[1][31:0];
        c.torque_c = torque_hist[2][31:0];
        c.wheel_a = sgn[0][16:0];
        c.wheel_b = sgn[1][16:0];
        c.wheel_c = sgn[2][16:0];
        return c;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_GAIN_ANGLE: k_angle = longint'(signed'(val));
            CFG_GAIN_RATE:  k_rate = longint'(signed'(val));
            CFG_GAIN_WHEEL: k_wheel = longint'(signed'(val));
            CFG_PRIOR_W:    w_prior = longint'(val[16:0]);
            CFG_SP_RATE:    sp_rate = longint'(val[30:0]);
            CFG_SP_LIMIT:   sp_limit = longint'(val[30:0]);
            default: ;
        endcase
    endtask

    // every result arrives with its item, so an empty queue means idle
    task automatic drain_results();
        while (expected_cmds.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_sample(sample_t s);
        @(posedge clk);
        while (!quiet_phase && $urandom_range(99) < 7) @(posedge clk);
        in_valid <= 1'b1;
        smp <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        in_valid <= 1'b0;
        expected_cmds.push_back(balance_step(s));
    endtask

    function automatic sample_t random_sample();
        sample_t s;
        s = sample_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        // mostly small steps, some at the extremes
        case ($urandom_range(3))
            0: s.dt = 16'($urandom_range(65535, 1));
            1: s.dt = 16'd0;
            default: s.dt = 16'($urandom_range(200, 1));
        endcase
        if ($urandom_range(9) == 0) s.ay = '0;
        if ($urandom_range(9) == 0) s.az = '0;
        if ($urandom_range(9) == 0) s.ax = '0;
        if ($urandom_range(2) == 0) s.wa = 16'($urandom_range(25599));
        if ($urandom_range(2) == 0) s.wb = 16'($urandom_range(25599));
        if ($urandom_range(2) == 0) s.wc = 16'($urandom_range(25599));
        return s;
    endfunction

    // result side: random stall, compare against the oldest expectation
    always @(posedge clk) begin
        command_t got, want;
        if (out_valid && out_ready) begin
            got = '{tq_a, tq_b, tq_c, sw_a, sw_b, sw_c};
            if (expected_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %p", got);
            end else begin
                want = expected_cmds.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch exp %p got %p", want, got);
                end
            end
        end
        out_ready <= quiet_phase || ($urandom_range(99) >= 7);
    end

    task automatic test_directed();
        sample_t s;
        sample_t edges [$];
        s = '0; s.dt = 16'd1; edges.push_back(s);                    // all zero: 0/0
        s = '0; s.az = 16'sh7fff; s.dt = 16'hffff; edges.push_back(s); // zero denominator
        s = '0; s.ax = -16'sh8000; s.ay = -16'sh8000; s.az = -16'sh8000;
        s.gx = -16'sh8000; s.gy = -16'sh8000; s.gz = -16'sh8000;
        s.wa = 16'hffff; s.wb = 16'd25599; s.wc = 16'd25600; s.dt = 16'hffff;
        edges.push_back(s);
        s.ax = 16'sh7fff; s.ay = 16'sh7fff; s.az = 16'sh7fff;
        s.gx = 16'sh7fff; s.gy = 16'sh7fff; s.gz = 16'sh7fff; edges.push_back(s);
        s.dt = 16'd0; edges.push_back(s);                              // zero time step
        s = '0; s.ay = 16'sd100; s.wa = 16'd10; s.wb = 16'd20; s.wc = 16'd30;
        s.dt = 16'd655; edges.push_back(s);
        foreach (edges[i]) send_sample(edges[i]);
        drain_results();
        // big gains drive saturation and negative torque makes wheels go negative
        write_reg(CFG_GAIN_ANGLE, 32'h7fffffff);
        write_reg(CFG_GAIN_RATE, 32'h80000000);
        write_reg(CFG_GAIN_WHEEL, 32'h00010000);
        write_reg(CFG_PRIOR_W, 32'h0001ffff);                          // weight above one
        write_reg(CFG_SP_RATE, 32'h7fffffff);
        write_reg(CFG_SP_LIMIT, 32'h7fffffff);
        foreach (edges[i]) send_sample(edges[i]);
        for (int i = 0; i < 8; i++) send_sample(random_sample());
        drain_results();
    endtask

    task automatic test_random_phase(int n, bit calm);
        quiet_phase = calm;
        for (int i = 0; i < n; i++) send_sample(random_sample());
        drain_results();
        quiet_phase = 1'b0;
    endtask

    task automatic set_gains(logic [31:0] ga, logic [31:0] gr, logic [31:0] gw,
                             logic [31:0] pw, logic [31:0] sr, logic [31:0] sl);
        write_reg(CFG_GAIN_ANGLE, ga);
        write_reg(CFG_GAIN_RATE, gr);
        write_reg(CFG_GAIN_WHEEL, gw);
        write_reg(CFG_PRIOR_W, pw);
        write_reg(CFG_SP_RATE, sr);
        write_reg(CFG_SP_LIMIT, sl);
    endtask

    initial begin
        for (int i = 0; i < 9; i++) est[i] = 0;
        for (int i = 0; i < 3; i++) begin
            torque_hist[i] = 0; sp_shift[i] = 0;
        end
        k_angle = 0; k_rate = 0; k_wheel = 0;
        w_prior = 3277; sp_rate = 655360; sp_limit = 6554;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        set_gains(32'h00020000, 32'h00008000, 32'h00000100, 32'd3277, 32'd655360, 32'd6554);
        test_random_phase(400, 1'b0);
        set_gains(-32'sd300000, 32'h0, -32'sd5000, 32'd0, 32'd0, 32'd0);
        test_random_phase(300, 1'b1);
        set_gains($urandom, $urandom, $urandom, 32'd65536, $urandom, $urandom_range(100000));
        test_random_phase(450, 1'b0);
        set_gains($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        test_random_phase(470, 1'b0);
        if (mismatches == 0 && expected_cmds.size() == 0)
            $display("[reaction_wheel_balance_controller_core] OK");
        else
            $display("[reaction_wheel_balance_controller_core] ERROR");
        $finish;
    end

    // about 1650 items with stalls; a generous limit on the run
    initial begin
        #10_000_000;
        $display("[reaction_wheel_balance_controller_core] ERROR");
        $finish;
    end
endmodule
